@@ rtl/tsat_pkg.sv @@
package tsat_pkg;

    // defaults for the top level parameters
    localparam int MAX_SECTIONS_DEF = 3;
    localparam int FRAC_BITS_DEF    = 8;

    // field widths
    localparam int OP_W       = 2;
    localparam int SEC_W      = 2;
    localparam int CARD_W     = 2;
    localparam int ANG_W      = 19;
    localparam int CH_W       = 4;
    localparam int PULSE_W    = 12;
    localparam int TUNER_W    = 11;
    localparam int TUNER_FRAC = 8;
    localparam int CNT_W      = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // increments before saturation, and the shared multiplier
    localparam int INC_W  = 26;
    localparam int MUL_W  = 29;
    localparam int PROD_W = 2 * MUL_W;

    // reciprocal scaling: divide by 1..3 and by 180
    localparam int RECIP_SHIFT = 25;
    localparam int DEG_SHIFT   = 35;
    localparam logic [MUL_W-1:0] RECIP_1   = MUL_W'(2 ** RECIP_SHIFT);
    localparam logic [MUL_W-1:0] RECIP_2   = MUL_W'(2 ** (RECIP_SHIFT - 1));
    localparam logic [MUL_W-1:0] RECIP_3   = MUL_W'((2 ** RECIP_SHIFT + 1) / 3);
    localparam logic [MUL_W-1:0] RECIP_180 = MUL_W'(190887436);

    // register reset values
    localparam logic [CNT_W-1:0]          SECTION_COUNT_RST = CNT_W'(3);
    localparam logic signed [TUNER_W-1:0] CARD_TUNER_RST    = TUNER_W'(256);
    localparam logic signed [TUNER_W-1:0] SECTION_TUNER_RST = TUNER_W'(256);
    localparam logic [PULSE_W-1:0]        PULSE_MIN_RST     = PULSE_W'(150);
    localparam logic [PULSE_W-1:0]        PULSE_MAX_RST     = PULSE_W'(600);

    // saturation bounds on the widened sum
    localparam logic signed [INC_W:0] SUM_MAX = (INC_W+1)'(2 ** (ANG_W - 1) - 1);
    localparam logic signed [INC_W:0] SUM_MIN = -(INC_W+1)'(2 ** (ANG_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SECTION_COUNT = 3'd0,
        CFG_CARD_TUNER    = 3'd1,
        CFG_SECTION_TUNER = 3'd2,
        CFG_PULSE_MIN     = 3'd3,
        CFG_PULSE_MAX     = 3'd4
    } cfg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_PULL     = 2'd0,
        OP_SET_EMIT = 2'd1,
        OP_EMIT     = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef struct packed {
        logic [CNT_W-1:0]          section_count;
        logic signed [TUNER_W-1:0] card_tuner;
        logic signed [TUNER_W-1:0] section_tuner;
        logic [PULSE_W-1:0]        pulse_min;
        logic [PULSE_W-1:0]        pulse_max;
    } cfg_t;

    typedef struct packed {
        logic                    en;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    // angle plus increment, saturated to the angle range
    function automatic logic signed [ANG_W-1:0] sat_add(
        input logic signed [ANG_W-1:0] ang,
        input logic signed [INC_W-1:0] inc
    );
        logic signed [INC_W:0] sum;
        sum = {{(INC_W + 1 - ANG_W){ang[ANG_W-1]}}, ang} + {inc[INC_W-1], inc};
        if (sum > SUM_MAX)
            return SUM_MAX[ANG_W-1:0];
        else if (sum < SUM_MIN)
            return SUM_MIN[ANG_W-1:0];
        else
            return sum[ANG_W-1:0];
    endfunction

    // scaled reciprocal of a small divisor
    function automatic logic [MUL_W-1:0] recip(input logic [1:0] d);
        logic [MUL_W-1:0] r;
        unique case (d)
            2'd2:    r = RECIP_2;
            2'd3:    r = RECIP_3;
            default: r = RECIP_1;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/tsat_if.sv @@
interface tsat_cmd_if;
    import tsat_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [SEC_W-1:0]        section;
    logic [CARD_W-1:0]       card;
    logic signed [ANG_W-1:0] value;

    modport source (output valid, output operation, output section, output card,
                    output value, input ready);
    modport sink   (input valid, input operation, input section, input card,
                    input value, output ready);
endinterface

interface tsat_res_if;
    import tsat_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         channel;
    logic [PULSE_W-1:0]      pulse;
    logic signed [ANG_W-1:0] angle_out;
    logic                    last;

    modport source (output valid, output channel, output pulse, output angle_out,
                    output last, input ready);
    modport sink   (input valid, input channel, input pulse, input angle_out,
                    input last, output ready);
endinterface

@@ rtl/tsat_mul.sv @@
module tsat_mul (
    input  logic                                 clk,
    input  tsat_pkg::mul_req_t                   req,
    output logic signed [tsat_pkg::PROD_W-1:0]   p
);
    import tsat_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    // registered signed product, held while not enabled
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            p_reg <= req.a * req.b;
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/tsat_seq.sv @@
module tsat_seq #(
    parameter int MAX_SECTIONS = tsat_pkg::MAX_SECTIONS_DEF,
    parameter int FRAC_BITS    = tsat_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tsat_cmd_if.sink                           cmd,
    tsat_res_if.source                         rsp,
    input  tsat_pkg::cfg_t                     cfg,
    output tsat_pkg::mul_req_t                 mul_req,
    input  logic signed [tsat_pkg::PROD_W-1:0] mul_p
);
    import tsat_pkg::*;

    localparam int DEPTH    = 4 * MAX_SECTIONS;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int USED_CAP = (MAX_SECTIONS > 3) ? 3 : MAX_SECTIONS;
    localparam int NUM_W    = ANG_W + 2;
    localparam int DEG_W    = ANG_W + 1;
    localparam logic [3:0] MAXS = 4'(MAX_SECTIONS);
    localparam logic signed [PROD_W-1:0] TUNER_BIAS = PROD_W'(2 ** (2 * TUNER_FRAC) - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SET, S_READ, S_PULL,
        S_EM_START, S_EM_M1, S_EM_M2, S_EM_OUT,
        S_LO_M1, S_LO_M2, S_LO_SH, S_LO_A0, S_LO_A1, S_LO_A2,
        S_UP_START, S_UP_M1, S_UP_A0, S_UP_M2, S_UP_A1, S_UP_A2
    } state_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [SEC_W-1:0]        sec_reg, sec_next;
    logic [CARD_W-1:0]       card_reg, card_next;
    logic signed [ANG_W-1:0] value_reg, value_next;
    logic [1:0]              row_reg, row_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic                    sign_reg, sign_next;
    logic signed [INC_W-1:0] side_reg, side_next;
    logic                    ovalid_reg, ovalid_next;
    logic [CH_W-1:0]         ochan_reg, ochan_next;
    logic [PULSE_W-1:0]      opulse_reg, opulse_next;
    logic signed [ANG_W-1:0] oangle_reg, oangle_next;
    logic                    olast_reg, olast_next;

    logic signed [ANG_W-1:0] tbl_reg [DEPTH];

    logic                    tbl_we;
    logic [5:0]              widx_wide;
    logic [5:0]              ridx_wide;
    logic signed [ANG_W-1:0] wdata;
    logic signed [ANG_W-1:0] rd_ang;
    logic signed [INC_W-1:0] inc;
    logic                    use_set;

    logic [CNT_W-1:0]        used;
    logic [CH_W-1:0]         n_ch;
    logic [CARD_W-1:0]       cw;
    logic [CARD_W-1:0]       ccw;
    logic                    sec_ok;
    logic [SEC_W-1:0]        sec_m1;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_abs;
    logic [PROD_W-1:0]       p_abs;
    logic                    p_neg;
    logic [INC_W-2:0]        q_div;
    logic signed [INC_W-1:0] q_pos;
    logic signed [INC_W-1:0] share;
    logic signed [INC_W-1:0] side_now;
    logic signed [PROD_W-1:0] p_bias;
    logic signed [DEG_W-1:0] ang_b;
    logic signed [DEG_W-1:0] deg;
    logic signed [PULSE_W:0] diff;
    logic [22:0]             q_deg;
    logic signed [23:0]      xs;
    logic signed [23:0]      x;
    logic signed [23:0]      lo_s;
    logic signed [23:0]      hi_s;
    logic [PULSE_W-1:0]      pulse_calc;
    logic                    out_free;
    logic                    load_emit;
    logic [2:0]              row_p1;
    logic [1:0]              recip_d;

    // sections in use and neighbor cards
    assign used   = ({1'b0, cfg.section_count} > 3'(USED_CAP)) ? CNT_W'(USED_CAP)
                                                               : cfg.section_count;
    assign n_ch   = {used, 2'b00};
    assign cw     = card_reg + 2'd3;
    assign ccw    = card_reg + 2'd1;
    assign sec_ok = (sec_reg != '0) && ({2'b00, sec_reg} <= MAXS);
    assign sec_m1 = sec_reg - 2'd1;
    assign row_p1 = {1'b0, row_reg} + 3'd1;
    assign recip_d = row_p1[1:0];

    // pulled share numerator: value times section
    assign num = (sec_reg[1] ? {{1{value_reg[ANG_W-1]}}, value_reg, 1'b0} : '0)
               + (sec_reg[0] ? {{2{value_reg[ANG_W-1]}}, value_reg} : '0);
    assign num_abs = num[NUM_W-1] ? -num : num;

    // product magnitude and reciprocal quotient
    assign p_neg  = mul_p[PROD_W-1];
    assign p_abs  = p_neg ? -mul_p : mul_p;
    assign q_div  = mul_p[RECIP_SHIFT + INC_W - 2:RECIP_SHIFT];
    assign q_pos  = {1'b0, q_div};
    assign share  = num[NUM_W-1] ? -q_pos : q_pos;
    assign side_now = sign_reg ? -q_pos : q_pos;
    assign p_bias = (mul_p + (p_neg ? TUNER_BIAS : PROD_W'(0))) >>> (2 * TUNER_FRAC);

    // table read port
    assign rd_ang = tbl_reg[ridx_wide[IDX_W-1:0]];

    // angle to whole degrees, truncated toward zero
    assign ang_b = {rd_ang[ANG_W-1], rd_ang}
                 + (rd_ang[ANG_W-1] ? DEG_W'(2 ** FRAC_BITS - 1) : '0);
    assign deg   = ang_b >>> FRAC_BITS;
    assign diff  = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});

    // degree scaling by 180, offset and clamp
    assign q_deg = mul_p[DEG_SHIFT + 22:DEG_SHIFT];
    assign xs    = sign_reg ? -$signed({1'b0, q_deg}) : $signed({1'b0, q_deg});
    assign lo_s  = $signed({12'b0, cfg.pulse_min});
    assign hi_s  = $signed({12'b0, cfg.pulse_max});
    assign x     = xs + lo_s;

    always_comb
    begin
        if (x < lo_s)
            pulse_calc = cfg.pulse_min;
        else if (x > hi_s)
            pulse_calc = cfg.pulse_max;
        else
            pulse_calc = x[PULSE_W-1:0];
    end

    assign out_free = !ovalid_reg || rsp.ready;
    assign use_set  = (state_reg == S_SET);
    assign wdata    = use_set ? value_reg : sat_add(rd_ang, inc);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        sec_next    = sec_reg;
        card_next   = card_reg;
        value_next  = value_reg;
        row_next    = row_reg;
        ch_next     = ch_reg;
        sign_next   = sign_reg;
        side_next   = side_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        ochan_next  = ochan_reg;
        opulse_next = opulse_reg;
        oangle_next = oangle_reg;
        olast_next  = olast_reg;
        mul_req     = '0;
        tbl_we      = 1'b0;
        widx_wide   = {2'b00, row_reg, card_reg};
        ridx_wide   = {2'b00, row_reg, card_reg};
        inc         = '0;
        load_emit   = 1'b0;
        cmd.ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    op_next    = op_t'(cmd.operation);
                    sec_next   = cmd.section;
                    card_next  = cmd.card;
                    value_next = cmd.value;
                    unique case (op_t'(cmd.operation))
                        OP_PULL:     state_next = S_PULL;
                        OP_SET_EMIT: state_next = S_SET;
                        OP_EMIT:     state_next = S_EM_START;
                        OP_READ:     state_next = S_READ;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end

            S_SET:
            begin
                widx_wide = {2'b00, sec_m1, card_reg};
                tbl_we    = sec_ok;
                state_next = S_EM_START;
            end

            S_READ:
            begin
                ridx_wide = {2'b00, sec_m1, card_reg};
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ochan_next  = (sec_reg == '0) ? '0 : {sec_m1, card_reg};
                    opulse_next = '0;
                    oangle_next = sec_ok ? rd_ang : '0;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_PULL:
            begin
                row_next = '0;
                if (sec_reg == '0)
                    state_next = S_IDLE;
                else if (sec_reg > 2'd1)
                    state_next = S_LO_M1;
                else
                    state_next = S_UP_START;
            end

            // rows below the pulled section: shared side term first
            S_LO_M1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {{(MUL_W - TUNER_W){cfg.card_tuner[TUNER_W-1]}}, cfg.card_tuner};
                mul_req.b  = {{(MUL_W - TUNER_W){cfg.section_tuner[TUNER_W-1]}},
                              cfg.section_tuner};
                state_next = S_LO_M2;
            end

            S_LO_M2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = mul_p[MUL_W-1:0];
                mul_req.b  = {{(MUL_W - ANG_W){value_reg[ANG_W-1]}}, value_reg};
                state_next = S_LO_SH;
            end

            S_LO_SH:
            begin
                side_next  = p_bias[INC_W-1:0];
                state_next = S_LO_A0;
            end

            S_LO_A0:
            begin
                tbl_we     = 1'b1;
                inc        = {{(INC_W - ANG_W){value_reg[ANG_W-1]}}, value_reg};
                state_next = S_LO_A1;
            end

            S_LO_A1:
            begin
                widx_wide  = {2'b00, row_reg, cw};
                ridx_wide  = {2'b00, row_reg, cw};
                tbl_we     = 1'b1;
                inc        = side_reg;
                state_next = S_LO_A2;
            end

            S_LO_A2:
            begin
                widx_wide = {2'b00, row_reg, ccw};
                ridx_wide = {2'b00, row_reg, ccw};
                tbl_we    = 1'b1;
                inc       = side_reg;
                if ((row_p1 + 3'd1 < {1'b0, sec_reg}) && ({1'b0, row_p1} < MAXS))
                begin
                    row_next   = row_p1[1:0];
                    state_next = S_LO_A0;
                end
                else
                begin
                    state_next = S_UP_START;
                end
            end

            // pulled section and the ones above it
            S_UP_START:
            begin
                row_next = sec_m1;
                if (sec_m1 < used)
                    state_next = S_UP_M1;
                else
                    state_next = S_IDLE;
            end

            S_UP_M1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {{(MUL_W - NUM_W){1'b0}}, num_abs};
                mul_req.b  = recip(recip_d);
                state_next = S_UP_A0;
            end

            S_UP_A0:
            begin
                tbl_we     = 1'b1;
                inc        = share;
                mul_req.en = 1'b1;
                mul_req.a  = {{(MUL_W - TUNER_W){cfg.card_tuner[TUNER_W-1]}}, cfg.card_tuner};
                mul_req.b  = {{(MUL_W - NUM_W){num[NUM_W-1]}}, num};
                state_next = S_UP_M2;
            end

            S_UP_M2:
            begin
                sign_next  = p_neg;
                mul_req.en = 1'b1;
                mul_req.a  = p_abs[MUL_W + TUNER_FRAC - 1:TUNER_FRAC];
                mul_req.b  = recip(recip_d);
                state_next = S_UP_A1;
            end

            S_UP_A1:
            begin
                widx_wide  = {2'b00, row_reg, cw};
                ridx_wide  = {2'b00, row_reg, cw};
                tbl_we     = 1'b1;
                inc        = side_now;
                side_next  = side_now;
                state_next = S_UP_A2;
            end

            S_UP_A2:
            begin
                widx_wide = {2'b00, row_reg, ccw};
                ridx_wide = {2'b00, row_reg, ccw};
                tbl_we    = 1'b1;
                inc       = side_reg;
                if (row_p1 < {1'b0, used})
                begin
                    row_next   = row_p1[1:0];
                    state_next = S_UP_M1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // pulse emission, one channel at a time
            S_EM_START:
            begin
                ch_next = '0;
                if (used == '0)
                    state_next = S_IDLE;
                else
                    state_next = S_EM_M1;
            end

            S_EM_M1:
            begin
                ridx_wide  = {2'b00, ch_reg};
                mul_req.en = 1'b1;
                mul_req.a  = {{(MUL_W - DEG_W){deg[DEG_W-1]}}, deg};
                mul_req.b  = {{(MUL_W - PULSE_W - 1){diff[PULSE_W]}}, diff};
                state_next = S_EM_M2;
            end

            S_EM_M2:
            begin
                sign_next  = p_neg;
                mul_req.en = 1'b1;
                mul_req.a  = p_abs[MUL_W-1:0];
                mul_req.b  = RECIP_180;
                state_next = S_EM_OUT;
            end

            S_EM_OUT:
            begin
                if (out_free)
                begin
                    load_emit   = 1'b1;
                    ovalid_next = 1'b1;
                    ochan_next  = ch_reg;
                    opulse_next = pulse_calc;
                    oangle_next = '0;
                    olast_next  = (ch_reg == n_ch - 4'd1);
                    if (ch_reg == n_ch - 4'd1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 4'd1;
                        state_next = S_EM_M1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_PULL;
            sec_reg    <= '0;
            card_reg   <= '0;
            value_reg  <= '0;
            row_reg    <= '0;
            ch_reg     <= '0;
            sign_reg   <= 1'b0;
            side_reg   <= '0;
            ovalid_reg <= 1'b0;
            ochan_reg  <= '0;
            opulse_reg <= '0;
            oangle_reg <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            sec_reg    <= sec_next;
            card_reg   <= card_next;
            value_reg  <= value_next;
            row_reg    <= row_next;
            ch_reg     <= ch_next;
            sign_reg   <= sign_next;
            side_reg   <= side_next;
            ovalid_reg <= ovalid_next;
            ochan_reg  <= ochan_next;
            opulse_reg <= opulse_next;
            oangle_reg <= oangle_next;
            olast_reg  <= olast_next;
        end
    end

    // angle table, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else if (tbl_we)
        begin
            tbl_reg[widx_wide[IDX_W-1:0]] <= wdata;
        end
    end

    assign rsp.valid     = ovalid_reg;
    assign rsp.channel   = ochan_reg;
    assign rsp.pulse     = opulse_reg;
    assign rsp.angle_out = oangle_reg;
    assign rsp.last      = olast_reg;

`ifndef ASSERT_OFF
    a_tbl_idx: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (widx_wide < 6'(DEPTH)))
        else $error("table write outside the table");

    a_em_ch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EM_M1 || state_reg == S_EM_M2 || state_reg == S_EM_OUT)
        |-> (ch_reg < n_ch))
        else $error("emit channel beyond the sections in use");

    a_up_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_M1 || state_reg == S_UP_A0 || state_reg == S_UP_A2)
        |-> ({1'b0, row_reg} < {1'b0, used}))
        else $error("pull row beyond the sections in use");

    a_pulse_rng: assert property (@(posedge clk) disable iff (!rst_n)
        load_emit |-> ((pulse_calc >= cfg.pulse_min && pulse_calc <= cfg.pulse_max)
                       || pulse_calc == cfg.pulse_min || pulse_calc == cfg.pulse_max))
        else $error("pulse outside the clamp range");

    a_pull_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PULL || state_reg == S_LO_A0 || state_reg == S_UP_A0)
        |=> !(ovalid_reg && !$past(ovalid_reg)))
        else $error("pull produced a result");
`endif

endmodule

@@ rtl/tendon_servo_angle_table_unit.sv @@
// channel  dir  handshake      payload
// cmd      in   valid/ready    operation, section, card, value
// rsp      out  valid/ready    channel, pulse, angle_out, last
// cfg      in   cfg_we         cfg_index, cfg_data
//
// one command at a time through a sequencer around one registered multiplier
// pull: when rows lie below, the side term is formed first and each lower row is updated,
// then each row from the pulled one up is updated in turn
// emit: one pulse per channel, 4 channels per section in use; set writes the angle first
// read back returns the stored angle; output stalls hold the sequencer in its output state
// reset clears the angle table and loads the register defaults
module tendon_servo_angle_table_unit #(
    parameter int MAX_SECTIONS = tsat_pkg::MAX_SECTIONS_DEF,
    parameter int FRAC_BITS    = tsat_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tsat_cmd_if.sink                          cmd,
    tsat_res_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [tsat_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsat_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tsat_pkg::*;

    cfg_t                     cfg_reg, cfg_next;
    mul_req_t                 mul_req;
    logic signed [PROD_W-1:0] mul_p;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SECTION_COUNT: cfg_next.section_count = cfg_data[CNT_W-1:0];
                CFG_CARD_TUNER:    cfg_next.card_tuner    = cfg_data[TUNER_W-1:0];
                CFG_SECTION_TUNER: cfg_next.section_tuner = cfg_data[TUNER_W-1:0];
                CFG_PULSE_MIN:     cfg_next.pulse_min     = cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX:     cfg_next.pulse_max     = cfg_data[PULSE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.section_count <= SECTION_COUNT_RST;
            cfg_reg.card_tuner    <= CARD_TUNER_RST;
            cfg_reg.section_tuner <= SECTION_TUNER_RST;
            cfg_reg.pulse_min     <= PULSE_MIN_RST;
            cfg_reg.pulse_max     <= PULSE_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // shared multiplier
    tsat_mul u_mul (
        .clk (clk),
        .req (mul_req),
        .p   (mul_p)
    );

    // sequencer and angle table
    tsat_seq #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .cfg     (cfg_reg),
        .mul_req (mul_req),
        .mul_p   (mul_p)
    );

endmodule
